// ----- rtl/vna_pkg.sv -----
`timescale 1ns / 1ps
package vna_pkg;
    // field widths
    localparam int OPC_W     = 2;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 24;
    localparam int NRM_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // default store depth
    localparam int DEF_VERTEX_DEPTH = 1024;

    // opcodes
    localparam logic [OPC_W-1:0] OP_WRITE    = 2'd0;
    localparam logic [OPC_W-1:0] OP_TRIANGLE = 2'd1;
    localparam logic [OPC_W-1:0] OP_READ     = 2'd2;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_FACE_LIM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_LIM = 1'b1;
    localparam logic [CFG_W-1:0]     FACE_LIM_RST = 32'd429;
    localparam logic [CFG_W-1:0]     NORM_LIM_RST = 32'd26;

    // arithmetic widths
    localparam int EDGE_W  = 25;
    localparam int CROSS_W = 51;
    localparam int MAG_W   = 50;
    localparam int MUL_W   = 31;
    localparam int PROD_W  = 62;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 63;
    localparam int REM_W   = 47;
    localparam int QUO_W   = 15;
    localparam int NORM_SH = 30;

    localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;
endpackage

// ----- rtl/vna_in_if.sv -----
`timescale 1ns / 1ps
interface vna_in_if;
    import vna_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OPC_W-1:0]        opcode;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;

    modport source (output valid, opcode, vertex_index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, input ready);
    modport sink (input valid, opcode, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

// ----- rtl/vna_out_if.sv -----
`timescale 1ns / 1ps
interface vna_out_if;
    import vna_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        read_vertex;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    used_default;

    modport source (output valid, read_vertex, normal_x, normal_y, normal_z,
                    used_default, input ready);
    modport sink (input valid, read_vertex, normal_x, normal_y, normal_z,
                  used_default, output ready);
endinterface

// ----- rtl/vertex_normal_accumulator.sv -----
`timescale 1ns / 1ps
// Smooth vertex normal accumulator. A write transaction stores a Q15.8 position
// and zeroes that vertex's normal sum in the same cycle. A triangle transaction
// reads its three corners, forms the edge cross product and, unless degenerate,
// normalizes it and adds it with saturation to the three corner sums. A
// degenerate triangle is dropped; a large cross product is first shifted right
// until each component is under 2^30. A read transaction normalizes one sum and
// returns a unit Q1.14 normal, or (0,1,0) for a degenerate sum; a stalled
// result holds off the next input. The time is set by one shared 31x31
// multiplier, a 32-step bit-serial square root and three 15-step restoring
// divisions, one item at a time. After reset a clearing pass over all
// VERTEX_DEPTH entries zeroes the normal sums before the first transaction is
// accepted.
module vertex_normal_accumulator #(
    parameter int VERTEX_DEPTH = vna_pkg::DEF_VERTEX_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vna_in_if.sink                         i_in,
    vna_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [vna_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vna_pkg::CFG_W-1:0]      i_cfg_data
);
    import vna_pkg::*;

    localparam int AW = $clog2(VERTEX_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_T_RA, S_T_RB, S_T_RC, S_T_E2, S_CROSS, S_RD_ACC, S_RD_LD,
        S_MAG, S_SQ, S_SHIFT, S_SQRT, S_DIV_INIT, S_DIV_STEP, S_DIV_END,
        S_ACC_RD, S_ACC_WR, S_OUT
    } t_state;

    // index wrap by the store depth, conditional subtract per quotient bit
    function automatic logic [AW-1:0] f_wrap(input logic [IDX_W-1:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int k = 7; k >= 0; k--) begin
            if (r >= (32'(VERTEX_DEPTH) << k)) r = r - (32'(VERTEX_DEPTH) << k);
        end
        return AW'(r);
    endfunction

    t_state                   r_state;
    logic                     r_clr_busy;
    logic [AW-1:0]            r_clr_addr;
    logic [CFG_W-1:0]         r_face_lim;
    logic [CFG_W-1:0]         r_norm_lim;
    logic [OPC_W-1:0]         r_op;
    logic                     r_phase;
    logic [AW-1:0]            r_vi;
    logic [AW-1:0]            r_ca;
    logic [AW-1:0]            r_cb;
    logic [AW-1:0]            r_cc;
    logic [1:0]               r_c;
    logic [3:0]               r_k;
    logic signed [POS_W-1:0]  r_pa   [3];
    logic signed [EDGE_W-1:0] r_e1   [3];
    logic signed [EDGE_W-1:0] r_e2   [3];
    logic signed [CROSS_W-1:0] r_vec [3];
    logic [MAG_W-1:0]         r_mag  [3];
    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]         r_sum;
    logic [ROOT_W-1:0]        r_root;
    logic [ROOT_W-1:0]        r_bit;
    logic [REM_W-1:0]         r_rem;
    logic [REM_W-1:0]         r_dsh;
    logic [QUO_W-1:0]         r_q;
    logic signed [NRM_W-1:0]  r_nrm  [3];
    logic                     r_dflt;
    logic                     r_o_valid;
    logic [AW-1:0]            r_o_vi;
    logic signed [NRM_W-1:0]  r_o_nrm [3];
    logic                     r_o_dflt;

    logic [3*POS_W-1:0] pos_mem [VERTEX_DEPTH];
    logic [3*POS_W-1:0] acc_mem [VERTEX_DEPTH];
    logic [3*POS_W-1:0] r_pos_rd;
    logic [3*POS_W-1:0] r_acc_rd;

    logic                     c_in_acc;
    logic                     c_pos_we;
    logic [AW-1:0]            c_in_vi;
    logic [AW-1:0]            c_pos_ra;
    logic [AW-1:0]            c_corner;
    logic                     c_acc_we;
    logic [AW-1:0]            c_acc_wa;
    logic [AW-1:0]            c_acc_ra;
    logic [3*POS_W-1:0]       c_acc_wd;
    logic [3*POS_W-1:0]       c_sat_word;
    logic signed [POS_W:0]    c_acc_sum [3];
    logic signed [MUL_W-1:0]  c_mul_a;
    logic signed [MUL_W-1:0]  c_mul_b;
    logic signed [PROD_W-1:0] c_prod;
    logic [SUM_W-1:0]         c_sum;
    logic [MAG_W-1:0]         c_abs [3];
    logic                     c_big;
    logic                     c_wide;
    logic [ROOT_W-1:0]        c_trial;
    logic                     c_ge;
    logic [31:0]              c_len;
    logic [QUO_W-1:0]         c_q_clamp;
    logic [2:0]               c_j;
    logic                     c_o_load;

    // input handshake
    assign i_in.ready = (r_state == S_IDLE) && !r_clr_busy;
    assign c_in_acc   = i_in.valid && i_in.ready;
    assign c_pos_we   = c_in_acc && (i_in.opcode == OP_WRITE);
    assign c_in_vi    = f_wrap(i_in.vertex_index);

    // output channel
    assign o_out.valid        = r_o_valid;
    assign o_out.read_vertex  = IDX_W'(r_o_vi);
    assign o_out.normal_x     = r_o_nrm[0];
    assign o_out.normal_y     = r_o_nrm[1];
    assign o_out.normal_z     = r_o_nrm[2];
    assign o_out.used_default = r_o_dflt;

    // result register loads when empty or being drained
    assign c_o_load = (r_state == S_OUT) && (!r_o_valid || o_out.ready);

    // memory addressing
    always_comb begin
        unique case (r_state)
            S_T_RA:  c_pos_ra = r_ca;
            S_T_RB:  c_pos_ra = r_cb;
            default: c_pos_ra = r_cc;
        endcase
        unique case (r_c)
            2'd0:    c_corner = r_ca;
            2'd1:    c_corner = r_cb;
            default: c_corner = r_cc;
        endcase
    end

    // saturating add of the new normal to a stored sum
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_acc_sum[i] = (POS_W+1)'($signed(r_acc_rd[i*POS_W +: POS_W]))
                         + (POS_W+1)'(r_nrm[i]);
            if (c_acc_sum[i] > (POS_W+1)'(2**(POS_W-1) - 1))
                c_sat_word[i*POS_W +: POS_W] = {1'b0, {(POS_W-1){1'b1}}};
            else if (c_acc_sum[i] < -(POS_W+1)'(2**(POS_W-1)))
                c_sat_word[i*POS_W +: POS_W] = {1'b1, {(POS_W-1){1'b0}}};
            else
                c_sat_word[i*POS_W +: POS_W] = c_acc_sum[i][POS_W-1:0];
        end
    end

    // accumulator write arbitration: clearing pass, position write, update
    always_comb begin
        c_acc_we = 1'b0;
        c_acc_wa = c_corner;
        c_acc_wd = c_sat_word;
        if (r_clr_busy) begin
            c_acc_we = 1'b1;
            c_acc_wa = r_clr_addr;
            c_acc_wd = '0;
        end else if (c_pos_we) begin
            c_acc_we = 1'b1;
            c_acc_wa = c_in_vi;
            c_acc_wd = '0;
        end else if (r_state == S_ACC_WR) begin
            c_acc_we = 1'b1;
        end
        c_acc_ra = (r_state == S_RD_ACC) ? r_vi : c_corner;
    end

    // position store
    always_ff @(posedge i_clk) begin
        if (c_pos_we) pos_mem[c_in_vi] <= {i_in.pos_z, i_in.pos_y, i_in.pos_x};
        r_pos_rd <= pos_mem[c_pos_ra];
    end

    // normal sum store
    always_ff @(posedge i_clk) begin
        if (c_acc_we) acc_mem[c_acc_wa] <= c_acc_wd;
        r_acc_rd <= acc_mem[c_acc_ra];
    end

    // shared multiplier operands: cross terms or squares of magnitudes
    always_comb begin
        c_mul_a = '0;
        c_mul_b = '0;
        if (r_state == S_CROSS) begin
            unique case (r_k)
                4'd0: begin c_mul_a = MUL_W'(r_e1[1]); c_mul_b = MUL_W'(r_e2[2]); end
                4'd1: begin c_mul_a = MUL_W'(r_e1[2]); c_mul_b = MUL_W'(r_e2[1]); end
                4'd2: begin c_mul_a = MUL_W'(r_e1[2]); c_mul_b = MUL_W'(r_e2[0]); end
                4'd3: begin c_mul_a = MUL_W'(r_e1[0]); c_mul_b = MUL_W'(r_e2[2]); end
                4'd4: begin c_mul_a = MUL_W'(r_e1[0]); c_mul_b = MUL_W'(r_e2[1]); end
                4'd5: begin c_mul_a = MUL_W'(r_e1[1]); c_mul_b = MUL_W'(r_e2[0]); end
                default: begin c_mul_a = '0; c_mul_b = '0; end
            endcase
        end else if (r_state == S_SQ && r_k < 4'd3) begin
            c_mul_a = $signed({1'b0, r_mag[r_k[1:0]][NORM_SH-1:0]});
            c_mul_b = $signed({1'b0, r_mag[r_k[1:0]][NORM_SH-1:0]});
        end
    end

    assign c_prod = c_mul_a * c_mul_b;
    assign c_sum  = r_sum + SUM_W'($unsigned(r_prod));
    assign c_j    = 3'(r_k - 4'd1);

    // magnitudes and range checks
    always_comb begin
        c_big  = 1'b0;
        c_wide = 1'b0;
        for (int i = 0; i < 3; i++) begin
            c_abs[i] = r_vec[i][CROSS_W-1] ? MAG_W'(-r_vec[i]) : MAG_W'(r_vec[i]);
            c_big  = c_big | (|c_abs[i][MAG_W-1:16]);
            c_wide = c_wide | (|r_mag[i][MAG_W-1:NORM_SH]);
        end
    end

    // square root and divide steps
    assign c_trial   = r_root + r_bit;
    assign c_ge      = r_sum >= SUM_W'(c_trial);
    assign c_len     = (r_root[31:0] == 32'd0) ? 32'd1 : r_root[31:0];
    assign c_q_clamp = (r_q > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : r_q;

    // sequencer
    always_ff @(posedge i_clk) begin
        r_prod <= c_prod;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
            r_face_lim <= FACE_LIM_RST;
            r_norm_lim <= NORM_LIM_RST;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FACE_LIM: r_face_lim <= i_cfg_data;
                    REG_NORM_LIM: r_norm_lim <= i_cfg_data;
                endcase
            end
            // clearing pass after reset
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(VERTEX_DEPTH - 1)) r_clr_busy <= 1'b0;
            end
            // result valid flag
            if (c_o_load) r_o_valid <= 1'b1;
            else if (o_out.ready) r_o_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (c_in_acc) begin
                        r_vi    <= c_in_vi;
                        r_ca    <= f_wrap(i_in.corner_a);
                        r_cb    <= f_wrap(i_in.corner_b);
                        r_cc    <= f_wrap(i_in.corner_c);
                        r_op    <= i_in.opcode;
                        r_phase <= 1'b0;
                        r_c     <= '0;
                        r_k     <= '0;
                        if (i_in.opcode == OP_TRIANGLE) r_state <= S_T_RA;
                        else if (i_in.opcode == OP_READ) r_state <= S_RD_ACC;
                    end
                end
                S_T_RA: r_state <= S_T_RB;
                S_T_RB: begin
                    for (int i = 0; i < 3; i++)
                        r_pa[i] <= $signed(r_pos_rd[i*POS_W +: POS_W]);
                    r_state <= S_T_RC;
                end
                S_T_RC: begin
                    for (int i = 0; i < 3; i++)
                        r_e1[i] <= EDGE_W'($signed(r_pos_rd[i*POS_W +: POS_W]))
                                 - EDGE_W'(r_pa[i]);
                    r_state <= S_T_E2;
                end
                S_T_E2: begin
                    for (int i = 0; i < 3; i++)
                        r_e2[i] <= EDGE_W'($signed(r_pos_rd[i*POS_W +: POS_W]))
                                 - EDGE_W'(r_pa[i]);
                    r_k     <= '0;
                    r_state <= S_CROSS;
                end
                // six products, each pair folded into one cross component
                S_CROSS: begin
                    if (r_k != 4'd0) begin
                        if (!c_j[0]) r_vec[c_j[2:1]] <= CROSS_W'(r_prod);
                        else r_vec[c_j[2:1]] <= r_vec[c_j[2:1]] - CROSS_W'(r_prod);
                    end
                    if (r_k == 4'd6) begin
                        r_k     <= '0;
                        r_state <= S_MAG;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_RD_ACC: r_state <= S_RD_LD;
                S_RD_LD: begin
                    for (int i = 0; i < 3; i++)
                        r_vec[i] <= CROSS_W'($signed(r_acc_rd[i*POS_W +: POS_W]));
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= c_abs[i];
                    r_k <= '0;
                    if (r_op == OP_TRIANGLE && c_big) r_state <= S_SHIFT;
                    else r_state <= S_SQ;
                end
                // sum of squares through the shared multiplier
                S_SQ: begin
                    if (r_k == 4'd0) r_sum <= '0;
                    else r_sum <= c_sum;
                    if (r_k == 4'd3) begin
                        r_k <= '0;
                        if (r_phase) begin
                            r_root  <= '0;
                            r_bit   <= ROOT_W'(1) << (ROOT_W - 1);
                            r_state <= S_SQRT;
                        end else if (r_op == OP_READ) begin
                            if (c_sum <= SUM_W'(r_norm_lim)) begin
                                r_nrm[0] <= '0;
                                r_nrm[1] <= ONE_Q14;
                                r_nrm[2] <= '0;
                                r_dflt   <= 1'b1;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_SHIFT;
                            end
                        end else if (c_sum <= SUM_W'(r_face_lim)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                // scale all magnitudes down until each fits 30 bits
                S_SHIFT: begin
                    if (c_wide) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else begin
                        r_phase <= 1'b1;
                        r_k     <= '0;
                        r_state <= S_SQ;
                    end
                end
                // bit-serial integer square root
                S_SQRT: begin
                    if (c_ge) begin
                        r_sum  <= r_sum - SUM_W'(c_trial);
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_c     <= '0;
                        r_state <= S_DIV_INIT;
                    end
                end
                // rounded quotient of magnitude times one over length
                S_DIV_INIT: begin
                    r_rem   <= REM_W'({r_mag[r_c][NORM_SH-1:0], 14'd0})
                             + REM_W'(c_len >> 1);
                    r_dsh   <= REM_W'(c_len) << 14;
                    r_k     <= '0;
                    r_state <= S_DIV_STEP;
                end
                S_DIV_STEP: begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[QUO_W-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QUO_W-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    if (r_k == 4'(QUO_W - 1)) r_state <= S_DIV_END;
                    else r_k <= r_k + 4'd1;
                end
                S_DIV_END: begin
                    r_nrm[r_c] <= r_vec[r_c][CROSS_W-1] ? -NRM_W'(c_q_clamp)
                                                        : NRM_W'(c_q_clamp);
                    if (r_c == 2'd2) begin
                        r_c    <= '0;
                        r_dflt <= 1'b0;
                        if (r_op == OP_READ) r_state <= S_OUT;
                        else r_state <= S_ACC_RD;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_DIV_INIT;
                    end
                end
                // read-modify-write of each corner in turn
                S_ACC_RD: r_state <= S_ACC_WR;
                S_ACC_WR: begin
                    if (r_c == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_ACC_RD;
                    end
                end
                S_OUT: begin
                    if (c_o_load) begin
                        r_o_vi    <= r_vi;
                        r_o_nrm   <= r_nrm;
                        r_o_dflt  <= r_dflt;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // no transaction is taken while the sums are being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("input accepted during clearing pass");

    // a degenerate sum always reads as straight up
    a_default_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.used_default) |->
        (o_out.normal_x == '0 && o_out.normal_y == ONE_Q14 && o_out.normal_z == '0))
        else $error("default normal is not (0,1,0)");

    // magnitudes are in range when the root starts
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_bit[ROOT_W-1]) |-> !c_wide)
        else $error("magnitude too wide for square root");

    // divide loop never overruns its quotient width
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_STEP) |-> (r_k <= 4'(QUO_W - 1)))
        else $error("divide step count overrun");
`endif
endmodule
